// ----- design/i2a_pkg.sv -----
// Shared types, constants and helpers for the integer to ASCII converter.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package i2a_pkg;

    // Conversion forms carried in the operation field.
    localparam logic [2:0] OP_U8_DEC  = 3'd0;
    localparam logic [2:0] OP_U8_HEX  = 3'd1;
    localparam logic [2:0] OP_U16_DEC = 3'd2;
    localparam logic [2:0] OP_U16_HEX = 3'd3;
    localparam logic [2:0] OP_U32_DEC = 3'd4;
    localparam logic [2:0] OP_U32_HEX = 3'd5;
    localparam logic [2:0] OP_S8_DEC  = 3'd6;
    localparam logic [2:0] OP_S16_DEC = 3'd7;

    localparam int MAX_CHARS = 10;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_A     = 8'h41;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_PLUS  = 8'h2B;

    localparam logic [3:0] DEC_BASE   = 4'd10;
    localparam logic [3:0] S8_DIGITS  = 4'd3;
    localparam logic [3:0] S16_DIGITS = 4'd5;

    // floor(n / 10) == (n * RECIP_TEN) >> RECIP_SHIFT for every 32-bit n
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] value;
    } item_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
        logic [3:0] string_length;
    } char_t;

    // Classified job: magnitude plus how to print it.
    typedef struct packed {
        logic [31:0] mag;
        logic        is_hex;
        logic        is_signed;
        logic        neg;
        logic [3:0]  ndig;
    } job_t;

    // Finished string, least significant character at index 0.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [3:0]                len;
    } text_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d >= DEC_BASE) begin
            return ASCII_A + {4'h0, d - DEC_BASE};
        end
        return ASCII_ZERO + {4'h0, d};
    endfunction

endpackage

`default_nettype wire

// ----- design/integer_to_ascii_converter.sv -----
// Top level of the integer to ASCII converter.
// Depends on i2a_pkg and instantiates i2a_front, i2a_queue, i2a_convert and i2a_emit.
`default_nettype none

// Each input word carries a conversion form and a 32-bit value; the block
// returns the ASCII string one character word at a time, most significant
// character first, each word tagged with the string length and a last mark.
// Unsigned decimal and uppercase hex forms drop leading zeros (zero prints as
// a single '0'); signed 8- and 16-bit forms print a sign and then exactly 3 or
// 5 digits. The front end classifies a word in the cycle it is accepted and
// pushes it into a QUEUE_DEPTH-entry job queue, so input stalls only while
// that queue is full. The digit engine then peels the digits off one at a time
// (a multiply by the reciprocal of ten, or a 4-bit shift for hex) and then
// hands the string over, and it works on the next word while the emitter
// sends the current string. The emitter sends one character per cycle, unless
// the output stalls, from a registered output and picks up the next string in
// the cycle it loads the last character of the current one into that register.
// A stalled output holds its word while the front end keeps accepting until
// the job queue fills.

module integer_to_ascii_converter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire i2a_pkg::item_t  item_word,
    output logic                 char_valid,
    input  wire logic            char_stall,
    output i2a_pkg::char_t       char_word
);

    i2a_pkg::q_status_t q_status;
    i2a_pkg::job_t      push_job;
    i2a_pkg::job_t      head_job;
    i2a_pkg::text_t     xfer_text;
    logic               push;
    logic               pop;
    logic               xfer_valid;
    logic               emit_free;

    // Classify and push into the job queue.
    i2a_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_word  (item_word),
        .q_status   (q_status),
        .push       (push),
        .job        (push_job)
    );

    // Decouple the front end from the digit engine.
    i2a_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // Build each string a digit per cycle.
    i2a_convert u_convert (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head_job   (head_job),
        .pop        (pop),
        .xfer_valid (xfer_valid),
        .xfer_text  (xfer_text),
        .emit_free  (emit_free)
    );

    // Stream characters out through the output register.
    i2a_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .xfer_valid (xfer_valid),
        .xfer_text  (xfer_text),
        .emit_free  (emit_free),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word)
    );

    // After a push the job queue is never empty on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !q_status.empty)
        else $error("job queue empty right after a push");

    // Never pop an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty job queue");

    // Handed-over strings hold between one and ten characters.
    assert property (@(posedge clk) disable iff (!rst_n)
        xfer_valid |-> (xfer_text.len != 4'd0 && xfer_text.len <= 4'd10))
        else $error("string length out of range at hand-over");

    // Characters of one string all report the same length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !char_stall && !char_word.last_char) |=>
            (!char_valid || char_word.string_length == $past(char_word.string_length)))
        else $error("string length changed within a string");

endmodule

`default_nettype wire

// ----- design/i2a_front.sv -----
// Front end: accepts input words and classifies them into conversion jobs.
// Depends on i2a_pkg; pushes jobs into i2a_queue.
`default_nettype none

module i2a_front (
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire i2a_pkg::item_t    item_word,
    input  wire i2a_pkg::q_status_t q_status,
    output logic                   push,
    output i2a_pkg::job_t          job
);

    logic [7:0]  raw8;
    logic [15:0] raw16;

    assign raw8       = item_word.value[7:0];
    assign raw16      = item_word.value[15:0];
    assign item_stall = q_status.full;
    assign push       = item_valid && !q_status.full;

    always_comb
    begin
        job           = '0;
        job.mag       = {24'h0, raw8};
        case (item_word.operation)
            i2a_pkg::OP_U8_DEC:
            begin
                job.mag = {24'h0, raw8};
            end
            i2a_pkg::OP_U8_HEX:
            begin
                job.mag    = {24'h0, raw8};
                job.is_hex = 1'b1;
            end
            i2a_pkg::OP_U16_DEC:
            begin
                job.mag = {16'h0, raw16};
            end
            i2a_pkg::OP_U16_HEX:
            begin
                job.mag    = {16'h0, raw16};
                job.is_hex = 1'b1;
            end
            i2a_pkg::OP_U32_DEC:
            begin
                job.mag = item_word.value;
            end
            i2a_pkg::OP_U32_HEX:
            begin
                job.mag    = item_word.value;
                job.is_hex = 1'b1;
            end
            i2a_pkg::OP_S8_DEC:
            begin
                // unsigned negate keeps -128 as magnitude 128
                job.neg       = raw8[7];
                job.mag       = {24'h0, raw8[7] ? 8'(8'h0 - raw8) : raw8};
                job.is_signed = 1'b1;
                job.ndig      = i2a_pkg::S8_DIGITS;
            end
            i2a_pkg::OP_S16_DEC:
            begin
                job.neg       = raw16[15];
                job.mag       = {16'h0, raw16[15] ? 16'(16'h0 - raw16) : raw16};
                job.is_signed = 1'b1;
                job.ndig      = i2a_pkg::S16_DIGITS;
            end
            default:
            begin
                job.mag = {24'h0, raw8};
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/i2a_queue.sv -----
// Short first-word-fall-through queue of classified jobs between front and back.
// Depends on i2a_pkg for the job and status types.
`default_nettype none

module i2a_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire i2a_pkg::job_t      push_job,
    input  wire logic               pop,
    output i2a_pkg::job_t           head_job,
    output i2a_pkg::q_status_t      status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    i2a_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1)) begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    assign head_job     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ----- design/i2a_convert.sv -----
// Back-end digit engine: peels one digit per cycle, least significant first.
// Depends on i2a_pkg; pops i2a_queue and hands finished strings to i2a_emit.
`default_nettype none

module i2a_convert (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire i2a_pkg::q_status_t q_status,
    input  wire i2a_pkg::job_t      head_job,
    output logic                    pop,
    output logic                    xfer_valid,
    output i2a_pkg::text_t          xfer_text,
    input  wire logic               emit_free
);

    typedef enum logic [2:0] {
        CV_IDLE = 3'b001,
        CV_RUN  = 3'b010,
        CV_DONE = 3'b100
    } cv_state_t;

    cv_state_t state_reg, state_next;

    logic [31:0] mag_reg, mag_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        hex_reg, hex_next;
    logic        sgn_reg, sgn_next;
    logic        neg_reg, neg_next;
    logic [3:0]  ndig_reg, ndig_next;
    logic [3:0]  len_reg, len_next;
    logic [i2a_pkg::MAX_CHARS-1:0][7:0] buf_reg, buf_next;

    logic [63:0] prod;
    logic [31:0] q_dec, q_val, r_wide;
    logic [3:0]  r_val;
    logic [3:0]  cnt_inc;
    logic        load;

    assign xfer_valid     = (state_reg == CV_DONE);
    assign xfer_text.chars = buf_reg;
    assign xfer_text.len   = len_reg;
    assign cnt_inc        = cnt_reg + 4'd1;

    always_comb
    begin
        prod   = 64'(mag_reg) * 64'(i2a_pkg::RECIP_TEN);
        q_dec  = 32'(prod >> i2a_pkg::RECIP_SHIFT);
        r_wide = mag_reg - (q_dec << 3) - (q_dec << 1);
        q_val  = hex_reg ? (mag_reg >> 4) : q_dec;
        r_val  = hex_reg ? mag_reg[3:0] : r_wide[3:0];
    end

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        cnt_next   = cnt_reg;
        hex_next   = hex_reg;
        sgn_next   = sgn_reg;
        neg_next   = neg_reg;
        ndig_next  = ndig_reg;
        len_next   = len_reg;
        buf_next   = buf_reg;
        load       = 1'b0;

        case (state_reg)
            CV_IDLE:
            begin
                load = !q_status.empty;
            end
            CV_RUN:
            begin
                buf_next[cnt_reg] = i2a_pkg::digit_char(r_val);
                mag_next          = q_val;
                cnt_next          = cnt_inc;
                if (sgn_reg) begin
                    // fixed digit count, sign lands above the top digit
                    if (cnt_reg == ndig_reg - 4'd1) begin
                        buf_next[cnt_inc] = neg_reg ? i2a_pkg::ASCII_MINUS
                                                    : i2a_pkg::ASCII_PLUS;
                        len_next   = cnt_reg + 4'd2;
                        state_next = CV_DONE;
                    end
                end else if (q_val == '0) begin
                    // stop at the last nonzero digit: no leading zeros
                    len_next   = cnt_inc;
                    state_next = CV_DONE;
                end
            end
            CV_DONE:
            begin
                if (emit_free) begin
                    if (!q_status.empty) begin
                        load = 1'b1;
                    end else begin
                        state_next = CV_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase

        if (load) begin
            mag_next   = head_job.mag;
            hex_next   = head_job.is_hex;
            sgn_next   = head_job.is_signed;
            neg_next   = head_job.neg;
            ndig_next  = head_job.ndig;
            cnt_next   = '0;
            state_next = CV_RUN;
        end
        pop = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= CV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        cnt_reg  <= cnt_next;
        hex_reg  <= hex_next;
        sgn_reg  <= sgn_next;
        neg_reg  <= neg_next;
        ndig_reg <= ndig_next;
        len_reg  <= len_next;
        buf_reg  <= buf_next;
    end

endmodule

`default_nettype wire

// ----- design/i2a_emit.sv -----
// Back-end character emitter with registered output word.
// Depends on i2a_pkg; takes finished strings from i2a_convert.
`default_nettype none

module i2a_emit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            xfer_valid,
    input  wire i2a_pkg::text_t  xfer_text,
    output logic                 emit_free,
    output logic                 char_valid,
    input  wire logic            char_stall,
    output i2a_pkg::char_t       char_word
);

    logic           busy_reg, busy_next;
    logic [3:0]     pos_reg, pos_next;
    i2a_pkg::text_t text_reg, text_next;
    logic           out_valid_reg, out_valid_next;
    i2a_pkg::char_t out_word_reg, out_word_next;
    logic           advance;

    assign advance    = busy_reg && (!out_valid_reg || !char_stall);
    assign emit_free  = !busy_reg || (advance && (pos_reg == '0));
    assign char_valid = out_valid_reg;
    assign char_word  = out_word_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        text_next      = text_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;

        if (advance) begin
            // most significant character first
            out_word_next.char_code     = text_reg.chars[pos_reg];
            out_word_next.last_char     = (pos_reg == '0);
            out_word_next.string_length = text_reg.len;
            out_valid_next              = 1'b1;
            pos_next                    = pos_reg - 4'd1;
            if (pos_reg == '0) begin
                busy_next = 1'b0;
            end
        end else if (!char_stall) begin
            out_valid_next = 1'b0;
        end

        if (xfer_valid && emit_free) begin
            text_next = xfer_text;
            pos_next  = xfer_text.len - 4'd1;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        text_reg     <= text_next;
        out_word_reg <= out_word_next;
    end

endmodule

`default_nettype wire

// ----- verif/integer_to_ascii_converter_tb.sv -----
// Self-checking testbench for integer_to_ascii_converter: drives conversion words,
// predicts every ASCII character word and checks each one as it leaves the block.
// Depends on i2a_pkg and the integer_to_ascii_converter RTL.

module integer_to_ascii_converter_tb;

    // Cycles with no handshake on either channel before the run is declared hung.
    localparam int HANG_LIMIT    = 2000;
    // Tail wait after the last character: covers the longest digit loop and then some.
    localparam int TAIL_CYCLES   = 24;
    localparam int RANDOM_WORDS  = 19;

    // Holds the characters still owed by the block, oldest first, and checks
    // every character word that comes out against them.
    class char_scoreboard;
        i2a_pkg::char_t pending[$];
        int             mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endfunction

        // Expand one accepted conversion word into its string and queue it.
        function void note_word(i2a_pkg::item_t w);
            logic [31:0] mag;
            logic [31:0] radix;
            logic [31:0] d;
            logic [7:0]  raw8;
            logic [15:0] raw16;
            logic [7:0]  digit_text[i2a_pkg::MAX_CHARS];
            logic [7:0]  sign_code;
            bit          signed_form;
            int          ndig;
            int          first;
            int          len;
            int          i;

            signed_form = 1'b0;
            sign_code   = i2a_pkg::ASCII_PLUS;
            radix       = 32'(i2a_pkg::DEC_BASE);
            case (w.operation)
                i2a_pkg::OP_U8_DEC:
                begin
                    mag  = {24'd0, w.value[7:0]};
                    ndig = 3;
                end
                i2a_pkg::OP_U8_HEX:
                begin
                    mag   = {24'd0, w.value[7:0]};
                    radix = 32'd16;
                    ndig  = 2;
                end
                i2a_pkg::OP_U16_DEC:
                begin
                    mag  = {16'd0, w.value[15:0]};
                    ndig = 5;
                end
                i2a_pkg::OP_U16_HEX:
                begin
                    mag   = {16'd0, w.value[15:0]};
                    radix = 32'd16;
                    ndig  = 4;
                end
                i2a_pkg::OP_U32_DEC:
                begin
                    mag  = w.value;
                    ndig = 10;
                end
                i2a_pkg::OP_U32_HEX:
                begin
                    mag   = w.value;
                    radix = 32'd16;
                    ndig  = 8;
                end
                i2a_pkg::OP_S8_DEC:
                begin
                    signed_form = 1'b1;
                    raw8 = w.value[7:0];
                    if (raw8[7])
                    begin
                        sign_code = i2a_pkg::ASCII_MINUS;
                        raw8 = -raw8;   // -128 wraps to 8'h80, read unsigned as 128
                    end
                    mag  = {24'd0, raw8};
                    ndig = int'(i2a_pkg::S8_DIGITS);
                end
                default:
                begin
                    signed_form = 1'b1;
                    raw16 = w.value[15:0];
                    if (raw16[15])
                    begin
                        sign_code = i2a_pkg::ASCII_MINUS;
                        raw16 = -raw16;
                    end
                    mag  = {16'd0, raw16};
                    ndig = int'(i2a_pkg::S16_DIGITS);
                end
            endcase

            for (i = ndig - 1; i >= 0; i--)
            begin
                d    = mag % radix;
                mag  = mag / radix;
                digit_text[i] = (d > 32'd9) ? i2a_pkg::ASCII_A + 8'(d - 32'd10)
                                            : i2a_pkg::ASCII_ZERO + 8'(d);
            end

            // Unsigned forms drop leading zeros but always keep one digit;
            // signed forms keep the full padded width behind the sign.
            first = 0;
            if (!signed_form)
            begin
                while (first < ndig - 1 && digit_text[first] == i2a_pkg::ASCII_ZERO)
                    first++;
            end
            len = ndig - first + (signed_form ? 1 : 0);

            if (signed_form)
                pending.push_back(i2a_pkg::char_t'{char_code: sign_code, last_char: 1'b0,
                                                   string_length: 4'(len)});
            for (i = first; i < ndig; i++)
                pending.push_back(i2a_pkg::char_t'{char_code: digit_text[i],
                                                   last_char: (i == ndig - 1),
                                                   string_length: 4'(len)});
        endfunction

        function void check_char(i2a_pkg::char_t got);
            i2a_pkg::char_t want;

            if (pending.size() == 0)
            begin
                report($sformatf("unexpected char word %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.char_code != want.char_code)
                report($sformatf("char_code %h, want %h", got.char_code, want.char_code));
            if (got.last_char != want.last_char)
                report($sformatf("last_char %b, want %b (char %h)",
                                 got.last_char, want.last_char, want.char_code));
            if (got.string_length != want.string_length)
                report($sformatf("string_length %0d, want %0d (char %h)",
                                 got.string_length, want.string_length, want.char_code));
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           item_valid = 1'b0;
    logic           item_stall;
    i2a_pkg::item_t item_word = '0;
    logic           char_valid;
    logic           char_stall = 1'b0;
    i2a_pkg::char_t char_word;

    // Idle and stall odds in percent, changed per phase by the stimulus.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    char_scoreboard sb = new();

    integer_to_ascii_converter DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_word  (item_word),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver back-pressure: redraw the stall every cycle at the phase's odds.
    always @(posedge clk)
    begin
        char_stall <= ($urandom_range(99) < stall_pct);
    end

    // Sample both handshakes at the edge. Every input of the block changes only
    // through nonblocking updates, so the values read here are the ones the
    // block sees at this edge. Note the input first so a same-edge check
    // always finds its expectation queued.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                sb.note_word(item_word);
            if (char_valid && !char_stall)
                sb.check_char(char_word);
        end
    end

    // Hang detection: count cycles with no word moving on either side.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (char_valid && !char_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Present one word, idling first at the phase's odds, and hold it until
    // the block takes it. Valid stays high into the next word when no idle
    // cycle is drawn, so back-to-back words get through too.
    task automatic send_word(input logic [2:0] operation, input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_word  <= i2a_pkg::item_t'{operation: operation, value: value};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Drop valid and hold off until every owed character has come out.
    task automatic drain_strings();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Random value biased toward short numbers, sign boundaries and junk in
    // the unused high bits, with plenty of full-width values as well.
    function automatic logic [31:0] pick_value();
        logic [31:0] junk;

        junk = $urandom;
        case ($urandom_range(4))
            0:       return $urandom_range(20);
            1:       return junk >> $urandom_range(31);
            2:       return {junk[31:16], 16'h8000 ^ 16'($urandom_range(1))};
            3:       return {junk[31:8], 8'h80 ^ 8'($urandom_range(1))};
            default: return junk;
        endcase
    endfunction

    initial
    begin
        int phase;
        int n;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: every form at its largest value, zero in every form but 16-bit
        // hex, the most negative signed values and set high bits that must be ignored.
        send_word(i2a_pkg::OP_U8_DEC,  32'd0);
        send_word(i2a_pkg::OP_U8_DEC,  32'd255);
        send_word(i2a_pkg::OP_U8_DEC,  32'hFFFF_FF0A);
        send_word(i2a_pkg::OP_U8_HEX,  32'd0);
        send_word(i2a_pkg::OP_U8_HEX,  32'h0000_00FF);
        send_word(i2a_pkg::OP_U8_HEX,  32'h1234_560B);
        send_word(i2a_pkg::OP_U16_DEC, 32'd0);
        send_word(i2a_pkg::OP_U16_DEC, 32'h0000_FFFF);
        send_word(i2a_pkg::OP_U16_DEC, 32'hABCD_0064);
        send_word(i2a_pkg::OP_U16_HEX, 32'h0000_FFFF);
        send_word(i2a_pkg::OP_U16_HEX, 32'hFFFF_1000);
        send_word(i2a_pkg::OP_U32_DEC, 32'd0);
        send_word(i2a_pkg::OP_U32_DEC, 32'hFFFF_FFFF);
        send_word(i2a_pkg::OP_U32_DEC, 32'd1_000_000_000);
        send_word(i2a_pkg::OP_U32_HEX, 32'd0);
        send_word(i2a_pkg::OP_U32_HEX, 32'hFFFF_FFFF);
        send_word(i2a_pkg::OP_U32_HEX, 32'h8000_0000);
        send_word(i2a_pkg::OP_S8_DEC,  32'h0000_0080);
        send_word(i2a_pkg::OP_S8_DEC,  32'h0000_007F);
        send_word(i2a_pkg::OP_S8_DEC,  32'hFFFF_FFFF);
        send_word(i2a_pkg::OP_S8_DEC,  32'hFFFF_FF00);
        send_word(i2a_pkg::OP_S16_DEC, 32'h0000_8000);
        send_word(i2a_pkg::OP_S16_DEC, 32'h0000_7FFF);
        send_word(i2a_pkg::OP_S16_DEC, 32'h0000_FFFF);
        send_word(i2a_pkg::OP_S16_DEC, 32'h1234_0000);
        drain_strings();

        // Random phases: free running, sender idling, receiver stalling, both.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 49;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 49;
                end
                default:
                begin
                    send_idle_pct = 33;
                    stall_pct     = 33;
                end
            endcase
            for (n = 0; n < RANDOM_WORDS; n++)
                send_word(3'($urandom), pick_value());
            drain_strings();
        end

        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d characters never arrived", sb.pending.size()));

        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
